[rtl/nva_pkg.sv]
// Shared constants and types for the nearest value add unit.
`timescale 1ns / 1ps

package nva_pkg;

	localparam int TABLE_DEPTH = 16384;
	localparam int DATA_W      = 16;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int DIST_W      = DATA_W + 1;
	localparam int SUM_W       = DATA_W + 1;

	localparam logic [1:0] FUNC_CLEAR = 2'd0;
	localparam logic [1:0] FUNC_LOAD  = 2'd1;
	localparam logic [1:0] FUNC_QUERY = 2'd2;

	// tag travelling with each table read word
	typedef struct packed {
		logic vld;
		logic first;
	} nva_rd_t;

endpackage

[rtl/nva_best.sv]
// Distance compare and best-entry tracker for the table scan.
`timescale 1ns / 1ps

module nva_best (
	input  logic                              clk,
	input  nva_pkg::nva_rd_t                  rd,
	input  logic signed [nva_pkg::DATA_W-1:0] query,
	input  logic signed [nva_pkg::DATA_W-1:0] data,
	output logic signed [nva_pkg::DATA_W-1:0] best
);

	logic signed [nva_pkg::DIST_W-1:0] diff;
	logic        [nva_pkg::DIST_W-1:0] abs_diff;
	logic        [nva_pkg::DIST_W-1:0] best_dist_q;
	logic signed [nva_pkg::DATA_W-1:0] best_q;
	logic                              take;

	always_comb begin
		diff     = nva_pkg::DIST_W'(data) - nva_pkg::DIST_W'(query);
		abs_diff = diff[nva_pkg::DIST_W-1] ? nva_pkg::DIST_W'(-diff) : nva_pkg::DIST_W'(diff);
		// strict less keeps the earliest entry on a tie
		take = rd.vld && (rd.first || (abs_diff < best_dist_q));
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_q      <= data;
			best_dist_q <= abs_diff;
		end
	end

	assign best = best_q;

endmodule

[rtl/nearest_value_add_unit.sv]
// Top level: table memory, scan sequencer and result register.
`timescale 1ns / 1ps

// Nearest value add unit. Holds a table of up to 16384 signed 16-bit
// reference values in one single-port-read, single-port-write memory.
// func=0 clears the table and the dropped-load flag; func=1 appends value
// (when full the load is dropped and overflow becomes sticky until the next
// clear); func=2 scans all loaded entries and returns the entry nearest to
// value (earliest wins on a tie), value+entry as a 17-bit sum, found and
// overflow. An empty table returns nearest=0, sum=value, found=0.
// Clear, load and unused code 3 give no result.
// A query holds the input side: one entry per cycle is read through the
// single memory read port (an empty table skips the scan), the drain state
// covers read latency and compare, and the done state hands the result to the
// output register. The done state stretches for as long as the output
// register still holds an earlier result that out_ready has not taken.
// Each result sits in an output register, so the next item is accepted
// while a result still waits for out_ready. No clearing pass is needed
// after reset: only entries below the fill count are read.
module nearest_value_add_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        func,
	input  logic signed [nva_pkg::DATA_W-1:0] value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [nva_pkg::DATA_W-1:0] nearest,
	output logic signed [nva_pkg::SUM_W-1:0]  sum,
	output logic                              found,
	output logic                              overflow
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	state_t                             state_q;
	logic [nva_pkg::CNT_W-1:0]          count_q;
	logic                               dropped_q;
	logic [nva_pkg::ADDR_W-1:0]         idx_q;
	logic signed [nva_pkg::DATA_W-1:0]  query_q;
	logic                               found_q;

	logic                               out_valid_q;
	logic signed [nva_pkg::DATA_W-1:0]  nearest_q;
	logic signed [nva_pkg::SUM_W-1:0]   sum_q;
	logic                               found_out_q;
	logic                               overflow_q;

	logic [nva_pkg::DATA_W-1:0]         mem [nva_pkg::TABLE_DEPTH];
	logic signed [nva_pkg::DATA_W-1:0]  rd_data_s1;
	nva_pkg::nva_rd_t                   rd_s1;
	logic signed [nva_pkg::DATA_W-1:0]  best;

	logic                               in_acc;
	logic                               has_room;
	logic                               wr_en;
	logic                               rd_en;
	logic                               last_idx;
	logic                               out_free;
	logic signed [nva_pkg::DATA_W-1:0]  res_val;

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		in_acc   = in_valid && in_ready;
		has_room = (count_q < nva_pkg::CNT_W'(nva_pkg::TABLE_DEPTH));
		wr_en    = in_acc && (func == nva_pkg::FUNC_LOAD) && has_room;
		rd_en    = (state_q == ST_SCAN);
		last_idx = ({1'b0, idx_q} == nva_pkg::CNT_W'(count_q - nva_pkg::CNT_W'(1)));
		out_free = !out_valid_q || out_ready;
		res_val  = found_q ? best : '0;
	end

	// table memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[count_q[nva_pkg::ADDR_W-1:0]] <= value;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= '0;
		end else begin
			rd_s1.vld   <= rd_en;
			rd_s1.first <= rd_en && (idx_q == '0);
		end
	end

	nva_best u_best (
		.clk   (clk),
		.rd    (rd_s1),
		.query (query_q),
		.data  (rd_data_s1),
		.best  (best)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			dropped_q <= 1'b0;
			idx_q     <= '0;
			found_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						case (func)
							nva_pkg::FUNC_CLEAR: begin
								count_q   <= '0;
								dropped_q <= 1'b0;
							end
							nva_pkg::FUNC_LOAD: begin
								if (has_room) begin
									count_q <= count_q + nva_pkg::CNT_W'(1);
								end else begin
									dropped_q <= 1'b1;
								end
							end
							nva_pkg::FUNC_QUERY: begin
								idx_q   <= '0;
								found_q <= (count_q != '0);
								state_q <= (count_q != '0) ? ST_SCAN : ST_DONE;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (last_idx) begin
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q + nva_pkg::ADDR_W'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && (func == nva_pkg::FUNC_QUERY)) begin
			query_q <= value;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && out_free) begin
			nearest_q   <= res_val;
			sum_q       <= nva_pkg::SUM_W'(query_q) + nva_pkg::SUM_W'(res_val);
			found_out_q <= found_q;
			overflow_q  <= dropped_q;
		end
	end

	assign out_valid = out_valid_q;
	assign nearest   = nearest_q;
	assign sum       = sum_q;
	assign found     = found_out_q;
	assign overflow  = overflow_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= nva_pkg::CNT_W'(nva_pkg::TABLE_DEPTH))
		else $error("fill count beyond table depth");

	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_s1.vld |-> $past(state_q == ST_SCAN))
		else $error("read tag without scan");

	a_found_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) && found_q |-> (count_q != '0))
		else $error("found set on empty table");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result outside done state");

	a_table_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |=> $stable(count_q))
		else $error("table changed during scan");

endmodule

[bench/tb_nearest_value_add_unit.sv]
// Self-checking testbench for the nearest value add unit.
`timescale 1ns / 1ps

// Checks the nearest value add unit against a behavioural predictor.
// Items are queued by the initial block in phases. The phases are: directed
// corner cases, then a random mix of clear, load, query and the spare code
// on small tables. A negedge driver sends the queued items in random bursts.
// A negedge receiver applies its own back-pressure pattern. A posedge monitor
// predicts each accepted item and checks each accepted result in order.
module tb_nearest_value_add_unit;

	// the spare operation code is ignored by the block
	localparam logic [1:0] FUNC_SPARE = 2'd3;

	localparam int LONG_HOLD   = 200;     // receiver hold-off, cycles
	localparam int STALL_LIMIT = 100000;  // must exceed a full-table scan
	localparam int N_RANDOM    = 70;

	typedef struct packed {
		logic [1:0]                 op;
		logic [nva_pkg::DATA_W-1:0] operand;
	} nva_item_t;

	typedef struct {
		logic signed [nva_pkg::DATA_W-1:0] nearest;
		logic signed [nva_pkg::SUM_W-1:0]  sum;
		logic                              found;
		logic                              overflow;
	} nva_result_t;

	// receiver back-pressure modes
	typedef enum logic [1:0] {
		RX_OPEN,    // always ready
		RX_COIN,    // ready half the time
		RX_SPARSE   // ready a quarter of the time
	} rx_mode_t;

	logic                              clk = 1'b0;
	logic                              arst_n;
	logic                              in_valid;
	logic                              in_ready;
	logic [1:0]                        func;
	logic signed [nva_pkg::DATA_W-1:0] value;
	logic                              out_valid;
	logic                              out_ready;
	logic signed [nva_pkg::DATA_W-1:0] nearest;
	logic signed [nva_pkg::SUM_W-1:0]  sum;
	logic                              found;
	logic                              overflow;

	// items waiting for the driver, and results the block still owes
	nva_item_t   stim_q[$];
	nva_result_t due_results[$];

	// predictor copy of the table
	logic signed [nva_pkg::DATA_W-1:0] tbl_vals [nva_pkg::TABLE_DEPTH];
	int                                tbl_count   = 0;
	logic                              tbl_dropped = 1'b0;

	logic     in_hs = 1'b0;     // item taken at the last rising edge
	int       n_errors = 0;
	int       results_seen = 0;
	int       idle_cycles = 0;
	int       burst_left = 0;
	int       gap_left = 0;
	int       hold_left = 0;
	int       next_hold_at = 20;
	int       mode_left = 0;
	rx_mode_t rx_mode = RX_OPEN;

	nearest_value_add_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.func     (func),
		.value    (value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.nearest  (nearest),
		.sum      (sum),
		.found    (found),
		.overflow (overflow)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		n_errors++;
	endtask

	// Track the table and work out the result a query should give.
	// Scan from the first entry: a strictly smaller distance is needed to
	// replace the candidate, so the earliest entry wins a tie.
	task automatic predict_nearest(input logic [1:0] op,
			input logic signed [nva_pkg::DATA_W-1:0] v);
		nva_result_t r;
		int          i;
		int          qi;
		int          ei;
		int          d;
		int          best_dist;
		int          s;
		case (op)
			nva_pkg::FUNC_CLEAR: begin
				tbl_count   = 0;
				tbl_dropped = 1'b0;
			end
			nva_pkg::FUNC_LOAD: begin
				if (tbl_count < nva_pkg::TABLE_DEPTH) begin
					tbl_vals[tbl_count] = v;
					tbl_count++;
				end else begin
					tbl_dropped = 1'b1;
				end
			end
			nva_pkg::FUNC_QUERY: begin
				qi        = v;
				r.nearest = '0;
				best_dist = 0;
				for (i = 0; i < tbl_count; i++) begin
					ei = tbl_vals[i];
					d  = ei - qi;
					if (d < 0)
						d = -d;
					if (i == 0 || d < best_dist) begin
						r.nearest = tbl_vals[i];
						best_dist = d;
					end
				end
				ei         = r.nearest;
				s          = qi + ei;
				r.sum      = s[nva_pkg::SUM_W-1:0];
				r.found    = (tbl_count > 0);
				r.overflow = tbl_dropped;
				due_results.push_back(r);
			end
			default: ;  // spare code: no state change, no result
		endcase
	endtask

	task automatic queue_item(input logic [1:0] op, input int operand);
		nva_item_t it;
		it.op      = op;
		it.operand = operand[nva_pkg::DATA_W-1:0];
		stim_q.push_back(it);
	endtask

	// sender pause: nothing queued, nothing offered, nothing owed
	task automatic wait_drained();
		while (stim_q.size() != 0 || in_valid || due_results.size() != 0)
			@(posedge clk);
	endtask

	// Value mix: a few extremes, a cluster round a centre so that entries
	// land close together and tie, the rest spread over the whole range.
	function automatic int pick_value(input int centre);
		int sel;
		sel = $urandom_range(0, 19);
		if (sel < 3) begin
			case ($urandom_range(0, 5))
				0:       return -32768;
				1:       return -32767;
				2:       return -1;
				3:       return 0;
				4:       return 32766;
				default: return 32767;
			endcase
		end
		if (sel < 10)
			return centre + int'($urandom_range(0, 16)) - 8;
		return int'($urandom_range(0, 65535)) - 32768;
	endfunction

	// Driver: a new item goes out only once the previous one was taken.
	// Items go out in bursts with random gaps between them.
	always @(negedge clk) begin : drv
		nva_item_t it;
		logic      nxt_valid;
		if (arst_n && (!in_valid || in_hs)) begin
			nxt_valid = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (stim_q.size() > 0) begin
				it        = stim_q.pop_front();
				func      <= it.op;
				value     <= it.operand;
				nxt_valid = 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 15);
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end
			in_valid <= nxt_valid;
		end
	end

	// Receiver: switches between back-pressure modes over random stretches.
	// Every so often it holds off for a long stretch so that the output
	// register fills and the block has to stall its input.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (results_seen >= next_hold_at) begin
			hold_left    = LONG_HOLD;
			next_hold_at = next_hold_at + 45;
			out_ready    <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				rx_mode   = rx_mode_t'($urandom_range(0, 2));
				mode_left = $urandom_range(8, 64);
			end else begin
				mode_left--;
			end
			case (rx_mode)
				RX_OPEN:  out_ready <= 1'b1;
				RX_COIN:  out_ready <= $urandom_range(0, 1);
				default:  out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Monitor: the result is checked before the input is predicted, so that
	// a query taken at the same edge never meets its own expectation.
	always @(posedge clk) begin : mon
		nva_result_t want;
		in_hs <= in_valid && in_ready;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (due_results.size() == 0) begin
				report_mismatch("result with none expected, nearest", nearest, 0);
			end else begin
				want = due_results.pop_front();
				if (nearest !== want.nearest)
					report_mismatch("nearest", nearest, want.nearest);
				if (sum !== want.sum)
					report_mismatch("sum", sum, want.sum);
				if (found !== want.found)
					report_mismatch("found", found, want.found);
				if (overflow !== want.overflow)
					report_mismatch("overflow", overflow, want.overflow);
			end
		end
		if (arst_n && in_valid && in_ready)
			predict_nearest(func, value);
	end

	// watchdog on cycles with no item moving on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		logic signed [nva_pkg::DATA_W-1:0] gen_vals[$];
		int n_rand;
		int sel;
		int cap;
		int centre;
		int lv;
		int qv;
		int ia;
		int ib;

		arst_n    = 1'b0;
		in_valid  = 1'b0;
		func      = nva_pkg::FUNC_CLEAR;
		value     = '0;
		out_ready = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty table, extremes, ties and the spare code
		queue_item(nva_pkg::FUNC_QUERY, -32768);
		queue_item(nva_pkg::FUNC_QUERY, 32767);
		queue_item(FUNC_SPARE, 16'h5555);
		queue_item(nva_pkg::FUNC_LOAD, 32767);
		queue_item(nva_pkg::FUNC_LOAD, -32768);
		queue_item(nva_pkg::FUNC_LOAD, 0);
		queue_item(nva_pkg::FUNC_QUERY, 32767);
		queue_item(nva_pkg::FUNC_QUERY, -32768);
		queue_item(nva_pkg::FUNC_QUERY, 16384);
		queue_item(nva_pkg::FUNC_QUERY, -16384);   // tie between -32768 and 0
		queue_item(FUNC_SPARE, -1);
		queue_item(nva_pkg::FUNC_QUERY, 1);
		queue_item(nva_pkg::FUNC_CLEAR, 0);
		queue_item(nva_pkg::FUNC_QUERY, 0);
		queue_item(nva_pkg::FUNC_LOAD, 10);
		queue_item(nva_pkg::FUNC_LOAD, -10);
		queue_item(nva_pkg::FUNC_LOAD, 10);
		queue_item(nva_pkg::FUNC_QUERY, 0);        // tie, first 10 wins
		queue_item(nva_pkg::FUNC_QUERY, -10);
		queue_item(nva_pkg::FUNC_LOAD, 20);
		queue_item(nva_pkg::FUNC_QUERY, 15);       // tie between 10 and 20
		queue_item(nva_pkg::FUNC_QUERY, -1);
		queue_item(nva_pkg::FUNC_CLEAR, 0);
		wait_drained();

		// random: small tables, queries aimed at entries and midpoints
		n_rand = 0;
		cap    = $urandom_range(1, 32);
		centre = int'($urandom_range(0, 65535)) - 32768;
		while (n_rand < N_RANDOM) begin
			sel = $urandom_range(0, 99);
			if (sel < 4) begin
				queue_item(FUNC_SPARE, pick_value(centre));
			end else if (sel < 8 || gen_vals.size() >= cap) begin
				queue_item(nva_pkg::FUNC_CLEAR, pick_value(centre));
				gen_vals.delete();
				cap    = $urandom_range(1, 32);
				centre = int'($urandom_range(0, 65535)) - 32768;
				n_rand++;
			end else if (sel < 48) begin
				lv = pick_value(centre);
				gen_vals.push_back(lv[nva_pkg::DATA_W-1:0]);
				queue_item(nva_pkg::FUNC_LOAD, lv);
				n_rand++;
			end else begin
				sel = $urandom_range(0, 9);
				if (gen_vals.size() >= 2 && sel < 3) begin
					ia = gen_vals[$urandom_range(0, gen_vals.size() - 1)];
					ib = gen_vals[$urandom_range(0, gen_vals.size() - 1)];
					qv = (ia + ib) / 2;
				end else if (gen_vals.size() > 0 && sel < 5) begin
					ia = gen_vals[$urandom_range(0, gen_vals.size() - 1)];
					qv = ia + int'($urandom_range(0, 2)) - 1;
				end else begin
					qv = pick_value(centre);
				end
				queue_item(nva_pkg::FUNC_QUERY, qv);
				n_rand++;
			end
		end
		wait_drained();

		// catch any stray result after the last item
		repeat (20) @(posedge clk);
		if (due_results.size() != 0)
			report_mismatch("results still owed at end", due_results.size(), 0);
		if (n_errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/nva_pkg.sv
rtl/nva_best.sv
rtl/nearest_value_add_unit.sv
bench/tb_nearest_value_add_unit.sv
